### sv/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
`default_nettype none
package mlr_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DELTA_BITS    = COORD_BITS + 1;
   localparam int EAST_BITS     = COORD_BITS + 2;
   localparam int DEC_BITS      = COORD_BITS + 3;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;

   localparam coord_type COORD_ONE = coord_type'(1);

   typedef enum logic [2:0] {
      OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
   } octant_type;

   // Running segment, kept in octant-0 space.
   typedef struct packed {
      logic                 active;
      octant_type           octant;
      coord_type            cursor_u;
      coord_type            cursor_v;
      coord_type            stop_u;
      dec_type              decision;
      logic [EAST_BITS-1:0] step_east;
      dec_type              step_diagonal;
   } seg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      valid;
      logic      last;
   } pixel_type;

endpackage
`default_nettype wire

### sv/mlr_setup.sv
// Segment setup: octant classification and mapping of a new segment into octant 0.
`default_nettype none
module mlr_setup (
   input  mlr_pkg::coord_type start_x,
   input  mlr_pkg::coord_type start_y,
   input  mlr_pkg::coord_type end_x,
   input  mlr_pkg::coord_type end_y,
   output mlr_pkg::seg_type   seg
);
   import mlr_pkg::*;

   delta_type            dx, dy, du, dv;
   logic [DELTA_BITS-1:0] ax, ay;
   logic                 dx_pos, dy_pos, dx_npos, dy_npos;
   octant_type           oct;
   coord_type            su, sv;
   dec_type              du_w, dv_w;

   always_comb begin
      dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
      dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
      ax = dx[DELTA_BITS-1] ? -dx : dx;
      ay = dy[DELTA_BITS-1] ? -dy : dy;
      dx_pos  = !dx[DELTA_BITS-1];
      dy_pos  = !dy[DELTA_BITS-1];
      dx_npos = dx[DELTA_BITS-1] || (dx == '0);
      dy_npos = dy[DELTA_BITS-1] || (dy == '0);

      if (dx_pos && dy_pos) begin
         oct = (ax >= ay) ? OCT_0 : OCT_1;
      end else if (dx_npos && dy_pos) begin
         oct = (ay >= ax) ? OCT_2 : OCT_3;
      end else if (dx_npos && dy_npos) begin
         oct = (ax >= ay) ? OCT_4 : OCT_5;
      end else begin
         oct = (ay >= ax) ? OCT_6 : OCT_7;
      end

      // start point negation wraps modulo 2^COORD_BITS
      unique case (oct)
         OCT_0: begin du = dx;  dv = dy;  su = start_x;  sv = start_y;  end
         OCT_1: begin du = dy;  dv = dx;  su = start_y;  sv = start_x;  end
         OCT_2: begin du = dy;  dv = -dx; su = start_y;  sv = -start_x; end
         OCT_3: begin du = -dx; dv = dy;  su = -start_x; sv = start_y;  end
         OCT_4: begin du = -dx; dv = -dy; su = -start_x; sv = -start_y; end
         OCT_5: begin du = -dy; dv = -dx; su = -start_y; sv = -start_x; end
         OCT_6: begin du = -dy; dv = dx;  su = -start_y; sv = start_x;  end
         OCT_7: begin du = dx;  dv = -dy; su = start_x;  sv = -start_y; end
      endcase

      du_w = {{(DEC_BITS-DELTA_BITS){du[DELTA_BITS-1]}}, du};
      dv_w = {{(DEC_BITS-DELTA_BITS){dv[DELTA_BITS-1]}}, dv};

      seg.active        = (du != '0);
      seg.octant        = oct;
      seg.cursor_u      = su;
      seg.cursor_v      = sv;
      seg.stop_u        = su + du[COORD_BITS-1:0];
      seg.step_east     = {dv, 1'b0};
      seg.step_diagonal = (dv_w - du_w) <<< 1;
      seg.decision      = (dv_w <<< 1) - du_w;
   end

endmodule
`default_nettype wire

### sv/mlr_core.sv
// Segment state, midpoint step, map back to the original octant and result register.
`default_nettype none
module mlr_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               cmd,
   input  mlr_pkg::seg_type   load_seg,
   output mlr_pkg::pixel_type pixel,
   output logic               line_active
);
   import mlr_pkg::*;

   seg_type   seg_ff, seg_in;
   pixel_type pixel_ff, pixel_in;
   coord_type u, v, nu, nv;
   logic      fin;

   always_comb begin
      seg_in = seg_ff;
      fin    = 1'b0;
      u      = seg_ff.cursor_u;
      v      = seg_ff.cursor_v;
      pixel_in.valid = 1'b1;

      if (cmd == CMD_LOAD) begin
         seg_in = load_seg;
         fin    = !load_seg.active;
      end else if (seg_ff.active) begin
         if (seg_ff.decision[DEC_BITS-1]) begin
            seg_in.decision = seg_ff.decision + {1'b0, seg_ff.step_east};
         end else begin
            seg_in.cursor_v = seg_ff.cursor_v + COORD_ONE;
            seg_in.decision = seg_ff.decision + seg_ff.step_diagonal;
         end
         seg_in.cursor_u = seg_ff.cursor_u + COORD_ONE;
         fin             = (seg_in.cursor_u == seg_ff.stop_u);
         seg_in.active   = !fin;
      end else begin
         pixel_in.valid = 1'b0;
      end
      u  = seg_in.cursor_u;
      v  = seg_in.cursor_v;
      nu = -u;
      nv = -v;

      unique case (seg_in.octant)
         OCT_0: begin pixel_in.x = u;  pixel_in.y = v;  end
         OCT_1: begin pixel_in.x = v;  pixel_in.y = u;  end
         OCT_2: begin pixel_in.x = nv; pixel_in.y = u;  end
         OCT_3: begin pixel_in.x = nu; pixel_in.y = v;  end
         OCT_4: begin pixel_in.x = nu; pixel_in.y = nv; end
         OCT_5: begin pixel_in.x = nv; pixel_in.y = nu; end
         OCT_6: begin pixel_in.x = v;  pixel_in.y = nu; end
         OCT_7: begin pixel_in.x = u;  pixel_in.y = nv; end
      endcase

      // idle advance: empty result
      if (!pixel_in.valid) begin
         pixel_in.x = '0;
         pixel_in.y = '0;
      end
      pixel_in.last = pixel_in.valid && fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else if (step_en) begin
         seg_ff <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel       = pixel_ff;
   assign line_active = seg_ff.active;

endmodule
`default_nettype wire

### sv/midpoint_line_rasterizer.sv
// Midpoint line rasterizer: eight-octant segment stepping, one pixel per item.
//
// req channel: one item per command. tuser carries the command (load or advance);
// tdata carries start_x, start_y, end_x, end_y, read on load only.
// rsp channel: exactly one item per request item, in order. tdata carries
// pixel_x, pixel_y; tuser is pixel_valid (0 for an advance with no segment
// running, payload then zero); tlast marks the end pixel of the segment.
// A load gives the start pixel and drops any running segment.
// Each item passes the input register on acceptance, then the result register
// (input register, then result register), which drives rsp_tvalid and rsp_tdata.
// Throughput: one item per cycle while rsp_tready does not hold the result register;
// the decision update, cursor step and octant unmap all sit in the single stage
// between the two registers, and the segment state is updated as each item leaves that stage.
// When rsp_tready is low the result register holds, the input register fills,
// and req_tready drops once both are occupied.
// Reset clears both valid flags and the segment state (no segment running).
`default_nettype none
module midpoint_line_rasterizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_x, start_y, end_x, end_y, from bit 0 up
   input  logic [mlr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_x, pixel_y, from bit 0 up
   output logic [mlr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // pixel_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import mlr_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic [4*COORD_BITS-1:0]  in_data_ff;
   logic                     in_cmd_ff;
   logic                     step_en;
   logic                     req_fire;
   logic                     line_active;
   seg_type                  load_seg;
   pixel_type                pixel;

   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_data_ff <= '0;
         in_cmd_ff  <= CMD_LOAD;
      end else if (req_fire) begin
         in_data_ff <= req_tdata[4*COORD_BITS-1:0];
         in_cmd_ff  <= req_tuser;
      end
   end

   mlr_setup u_setup (
      .start_x (in_data_ff[COORD_BITS-1:0]),
      .start_y (in_data_ff[2*COORD_BITS-1:COORD_BITS]),
      .end_x   (in_data_ff[3*COORD_BITS-1:2*COORD_BITS]),
      .end_y   (in_data_ff[4*COORD_BITS-1:3*COORD_BITS]),
      .seg     (load_seg)
   );

   mlr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .cmd         (in_cmd_ff),
      .load_seg    (load_seg),
      .pixel       (pixel),
      .line_active (line_active)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({pixel.y, pixel.x});
   assign rsp_tuser  = pixel.valid;
   assign rsp_tlast  = pixel.last;

`ifndef SYNTHESIS
   a_load_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      step_en && (in_cmd_ff == CMD_LOAD) |=>
         rsp_tvalid && rsp_tuser && (rsp_tlast == !line_active))
      else $error("load did not give a pixel matching the segment state");

   a_idle_advance_empty: assert property (@(posedge clock) disable iff (reset)
      step_en && (in_cmd_ff == CMD_ADVANCE) && !line_active |=>
         rsp_tvalid && !rsp_tuser)
      else $error("advance with no segment gave a valid pixel");

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("empty result carries nonzero payload");

   a_last_ends_segment: assert property (@(posedge clock) disable iff (reset)
      step_en |=> (rsp_tuser && rsp_tlast) == (rsp_tuser && !line_active))
      else $error("last flag disagrees with segment state");
`endif

endmodule
`default_nettype wire
